>>> src/scf_pkg.sv
// Package for the sieve chain candidate finder: shared types and constants.
// No dependencies.
package scf_pkg;

   localparam int unsigned WHEEL = 30;

   typedef enum logic [1:0] {
      REG_MAX_GAP   = 2'd0,
      REG_MIN_SLOTS = 2'd1
   } reg_index_type;

   // One byte handed from the lookahead front to the chain back end.
   typedef struct packed {
      logic [7:0]  bitmap;
      logic [6:0]  hits;       // popcount over the lookahead window; seven bits hold up to fifteen bytes
      logic [31:0] byte_index;
      logic [63:0] segment_low;
   } work_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_BITS = 2'd1,
      BK_EMIT = 2'd2
   } back_state_type;

   function automatic logic [4:0] wheel_res(input logic [2:0] i);
      logic [4:0] r;
      unique case (i)
         3'd0: r = 5'd1;
         3'd1: r = 5'd7;
         3'd2: r = 5'd11;
         3'd3: r = 5'd13;
         3'd4: r = 5'd17;
         3'd5: r = 5'd19;
         3'd6: r = 5'd23;
         default: r = 5'd29;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] pop8(input logic [7:0] b);
      logic [3:0] c;
      c = '0;
      for (int i = 0; i < 8; i++) c = c + 4'(b[i]);
      return c;
   endfunction

endpackage

>>> src/scf_front.sv
// Lookahead front end: holds the window, emits one work item per evaluated byte.
// Depends on scf_pkg.
module scf_front #(
   parameter int LOOKAHEAD_BYTES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic [63:0]       in_low,
   input  logic              in_end,
   output logic              wk_valid,
   input  logic              wk_ready,
   output scf_pkg::work_type wk_data
);
   import scf_pkg::*;

   localparam int LA = LOOKAHEAD_BYTES;
   localparam int FW = $clog2(LA + 1);
   localparam int HW = $clog2(8 * LA + 1);
   localparam int IW = (LA > 1) ? $clog2(LA) : 1;

   logic [7:0]    win_ff   [LA];
   logic [7:0]    win_in   [LA];
   logic [FW-1:0] fill_ff, fill_in;
   logic          drain_ff, drain_in;
   logic [63:0]   low_ff, low_in;
   logic [31:0]   idx_ff, idx_in;
   logic [HW-1:0] hits;
   logic          emit;

   // hits summed over the filled part of the window
   always_comb begin
      hits = '0;
      for (int i = 0; i < LA; i++)
         if (FW'(i) < fill_ff) hits = hits + HW'(pop8(win_ff[i]));
   end

   // Evaluate when the window is full, or drain after segment end.
   assign emit     = (fill_ff == FW'(LA)) || (drain_ff && fill_ff != '0);
   assign wk_valid = emit;
   assign in_ready = !emit && !drain_ff;
   assign wk_data.bitmap      = win_ff[0];
   assign wk_data.hits        = 7'(hits);
   assign wk_data.byte_index  = idx_ff;
   assign wk_data.segment_low = low_ff;

   always_comb begin
      win_in   = win_ff;
      fill_in  = fill_ff;
      drain_in = drain_ff;
      low_in   = low_ff;
      idx_in   = idx_ff;
      if (emit && wk_ready) begin
         for (int i = 0; i < LA - 1; i++) win_in[i] = win_ff[i + 1];
         fill_in = fill_ff - 1'b1;
         idx_in  = idx_ff + 1'b1;
         if (drain_ff && fill_ff == FW'(1)) begin
            drain_in = 1'b0;
            idx_in   = '0;
         end
      end else if (in_valid && in_ready) begin
         // window is never full while input is taken
         win_in[IW'(fill_ff)] = in_byte;
         fill_in  = fill_ff + 1'b1;
         low_in   = in_low;
         drain_in = in_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         drain_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         fill_ff  <= fill_in;
         drain_ff <= drain_in;
         idx_ff   <= idx_in;
      end
      win_ff <= win_in;
      low_ff <= low_in;
   end
endmodule

>>> src/scf_queue.sv
// Short FIFO of work items between front and back end.
// Depends on scf_pkg.
module scf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  scf_pkg::work_type wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output scf_pkg::work_type rd_data
);
   import scf_pkg::*;

   work_type   mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (wr_valid && wr_ready) wp_ff <= !wp_ff;
         if (rd_valid && rd_ready) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
      end
      if (wr_valid && wr_ready) mem_ff[wp_ff] <= wr_data;
   end
endmodule

>>> src/scf_back.sv
// Chain back end: walks candidate bits one per cycle, pausing while a run is emitted, and emits member runs.
// Depends on scf_pkg.
module scf_back #(
   parameter int MAX_CHAIN_MEMBERS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wk_valid,
   output logic              wk_ready,
   input  scf_pkg::work_type wk_data,
   input  logic [5:0]        max_gap,
   input  logic [4:0]        min_slots,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [63:0]       out_base,
   output logic [9:0]        out_offset,
   output logic [3:0]        out_index,
   output logic [4:0]        out_length,
   output logic              out_last
);
   import scf_pkg::*;

   localparam int MW = $clog2(MAX_CHAIN_MEMBERS);
   localparam int CW = $clog2(MAX_CHAIN_MEMBERS + 1);

   back_state_type st_ff, st_in;
   logic [7:0]     bits_ff, bits_in;
   logic [4:0]     prev_ff, prev_in;
   logic           open_ff, open_in;
   logic [5:0]     carry_ff, carry_in;
   logic [63:0]    base_ff, base_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [63:0]    ebase_ff, ebase_in;
   logic [CW-1:0]  ecnt_ff, ecnt_in;
   logic [CW-1:0]  ek_ff, ek_in;
   logic           pend_ff, pend_in;   // byte end work remaining after a run
   logic           start_ff, start_in; // start new chain after run
   logic [9:0]     mem [MAX_CHAIN_MEMBERS];
   logic [9:0]     rd_ff;
   logic           wr_en;
   logic [MW-1:0]  wr_addr;
   logic [9:0]     wr_data;
   logic [63:0]    pos_ff, pos_in;     // low + idx*30
   logic [2:0]     bit_sel;
   logic [4:0]     off;
   logic [63:0]    cand;
   logic [6:0]     gap;
   logic           out_fire;
   logic           keep_run;           // open chain is long enough to emit

   always_comb begin
      bit_sel = 3'd7;
      for (int i = 7; i >= 0; i--) if (bits_ff[i]) bit_sel = 3'(i);
   end
   assign off  = wheel_res(bit_sel);
   assign cand = pos_ff + 64'(off);
   assign gap  = 7'(carry_ff) + 7'(off) - 7'(prev_ff);
   assign keep_run = 32'(cnt_ff) >= 32'(min_slots);

   assign wk_ready   = st_ff == BK_IDLE;
   assign out_valid  = st_ff == BK_EMIT && ek_ff != ecnt_ff;
   assign out_base   = ebase_ff;
   assign out_offset = rd_ff;
   assign out_index  = 4'(ek_ff);
   assign out_length = 5'(ecnt_ff);
   assign out_last   = ek_ff + 1'b1 == ecnt_ff;
   assign out_fire   = out_valid && out_ready;

   always_comb begin
      st_in = st_ff; bits_in = bits_ff; prev_in = prev_ff;
      open_in = open_ff; carry_in = carry_ff; base_in = base_ff; cnt_in = cnt_ff;
      ebase_in = ebase_ff; ecnt_in = ecnt_ff; ek_in = ek_ff; pend_in = pend_ff;
      start_in = start_ff; pos_in = pos_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0;
      unique case (st_ff)
         BK_IDLE: if (wk_valid) begin
            bits_in = wk_data.bitmap;
            prev_in = '0;
            pos_in  = wk_data.segment_low + 64'(wk_data.byte_index) * 64'(WHEEL);
            if (!open_ff && wk_data.hits < 7'(min_slots)) begin
               // skipped
            end else if (wk_data.bitmap == '0) begin
               if (open_ff) begin
                  open_in = 1'b0;
                  if (keep_run) begin
                     ebase_in = base_ff; ecnt_in = cnt_ff; ek_in = '0;
                     pend_in = 1'b0; start_in = 1'b0; st_in = BK_EMIT;
                  end
               end
            end else st_in = BK_BITS;
         end
         BK_BITS: begin
            if (bits_ff == '0) begin
               st_in = BK_IDLE;
               if (open_ff) begin
                  carry_in = 6'(WHEEL - 32'(prev_ff));
                  if (6'(WHEEL - 32'(prev_ff)) > max_gap) begin
                     open_in = 1'b0;
                     if (keep_run) begin
                        ebase_in = base_ff; ecnt_in = cnt_ff; ek_in = '0;
                        pend_in = 1'b0; start_in = 1'b0; st_in = BK_EMIT;
                     end
                  end
               end
            end else begin
               bits_in = bits_ff & ~(8'd1 << bit_sel);
               prev_in = off;
               if (open_ff && gap <= 7'(max_gap)) begin
                  if (cnt_ff < CW'(MAX_CHAIN_MEMBERS)) begin
                     wr_en = 1'b1; wr_addr = MW'(cnt_ff); wr_data = 10'(cand - base_ff);
                     cnt_in = cnt_ff + 1'b1;
                  end
                  carry_in = '0;
               end else begin
                  if (open_ff && keep_run) begin
                     ebase_in = base_ff; ecnt_in = cnt_ff; ek_in = '0;
                     pend_in = 1'b1; st_in = BK_EMIT;
                  end
                  // new chain starts now; member 0 is written now, or after the run drains if one is emitted
                  start_in = open_ff && keep_run;
                  base_in = cand; cnt_in = CW'(1); carry_in = '0; open_in = 1'b1;
                  if (!(open_ff && keep_run)) begin
                     wr_en = 1'b1; wr_addr = '0; wr_data = '0;
                  end
               end
            end
         end
         BK_EMIT: begin
            if (out_fire) ek_in = ek_ff + 1'b1;
            if (ek_ff == ecnt_ff) begin
               if (start_ff) begin
                  wr_en = 1'b1; wr_addr = '0; wr_data = '0; start_in = 1'b0;
               end
               st_in = pend_ff ? BK_BITS : BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   // Read address runs one ahead when a transfer completes.
   logic [MW-1:0] rd_addr;
   always_comb begin
      if (st_ff != BK_EMIT)      rd_addr = '0;
      else if (out_fire)         rd_addr = MW'(ek_ff + 1'b1);
      else                       rd_addr = MW'(ek_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE; open_ff <= 1'b0; carry_ff <= '0; base_ff <= '0;
         cnt_ff <= '0; pend_ff <= 1'b0; start_ff <= 1'b0;
      end else begin
         st_ff <= st_in; open_ff <= open_in; carry_ff <= carry_in; base_ff <= base_in;
         cnt_ff <= cnt_in; pend_ff <= pend_in; start_ff <= start_in;
      end
      bits_ff <= bits_in; prev_ff <= prev_in; ebase_ff <= ebase_in;
      ecnt_ff <= ecnt_in; ek_ff <= ek_in; pos_ff <= pos_in;
   end
endmodule

>>> src/sieve_chain_candidate_finder_unit.sv
// Sieve chain candidate finder, top level: CSR port, front, queue, back end.
// Depends on scf_pkg, scf_front, scf_queue, scf_back.
//
// Each sieve byte is evaluated once the lookahead window holds it and the
// following bytes, or at segment end. With the window full the front end
// alternates between taking a byte and passing the evaluated byte to the
// two-entry queue, taking no request while an evaluated byte waits. A
// segment end holds the input while the window drains, one byte per cycle
// while the queue has room. The back end takes a skipped or zero byte in
// its idle state and walks the set bits of any other; a closed chain of at
// least min_slots members then streams one member per cycle from the member
// memory while rsp_tready is high. The bit walk sets the rate; a full queue
// stalls the input. Results are taken on rsp_tvalid and rsp_tready.
module sieve_chain_candidate_finder_unit #(
   parameter int MAX_CHAIN_MEMBERS = 16,
   parameter int LOOKAHEAD_BYTES   = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,  // bitmap[7:0], segment_low[71:8]
   input  logic         req_tlast,  // segment_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // chain_base[63:0], member_offset[73:64], member_index[77:74], run_length[82:78]
   output logic [87:0]  rsp_tdata,
   output logic         rsp_tlast,  // run_last
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import scf_pkg::*;

   logic [5:0] max_gap_ff;
   logic [4:0] min_slots_ff;
   logic       f_valid, f_ready, q_valid, q_ready;
   work_type   f_data, q_data;
   logic [63:0] base;
   logic [9:0]  offset;
   logic [3:0]  index;
   logic [4:0]  length;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff   <= 6'd12;
         min_slots_ff <= 5'd8;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == 1'(REG_MAX_GAP))   max_gap_ff   <= csr_pwdata[5:0];
         if (csr_paddr[2] == 1'(REG_MIN_SLOTS)) min_slots_ff <= csr_pwdata[4:0];
      end
   end
   always_comb begin
      if (csr_paddr[2] == 1'(REG_MIN_SLOTS)) csr_prdata = {27'd0, min_slots_ff};
      else                                   csr_prdata = {26'd0, max_gap_ff};
   end

   scf_front #(.LOOKAHEAD_BYTES(LOOKAHEAD_BYTES)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_byte(req_tdata[7:0]), .in_low(req_tdata[71:8]), .in_end(req_tlast),
      .wk_valid(f_valid), .wk_ready(f_ready), .wk_data(f_data));

   scf_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data));

   scf_back #(.MAX_CHAIN_MEMBERS(MAX_CHAIN_MEMBERS)) u_back (
      .clock, .reset, .wk_valid(q_valid), .wk_ready(q_ready), .wk_data(q_data),
      .max_gap(max_gap_ff), .min_slots(min_slots_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_base(base),
      .out_offset(offset), .out_index(index), .out_length(length), .out_last(rsp_tlast));

   assign rsp_tdata = {5'd0, length, index, offset, base};
endmodule

>>> src/scf_checker.sv
// Port-level checker for the sieve chain candidate finder, with its bind.
// Depends on sieve_chain_candidate_finder_unit.
module scf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_pready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp stalled payload changed");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[77:74] + 4'd1 == rsp_tdata[82:78] ||
      rsp_tdata[82:78] == 5'd16)
      else $error("last member index mismatch");
   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !rsp_tvalid ||
      rsp_tdata[77:74] == $past(rsp_tdata[77:74]) + 4'd1)
      else $error("member index skipped");
   a_rdy: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind sieve_chain_candidate_finder_unit scf_checker u_scf_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .csr_pready);
